[hw/rtl/dlf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlf_pkg
// Types and constants shared by the delimiter line framer.
// ----------------------------------------------------------------------------
package dlf_pkg;

	localparam int STORE_DEPTH_DEF         = 64;
	localparam int MAX_DELIMITER_BYTES_DEF = 4;

	localparam int CFG_INDEX_W = 3;
	localparam int LIMIT_W     = 6;
	localparam int PATTERN_W   = 32;
	localparam int DLEN_W      = 3;

	localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 6'd63;
	localparam logic                 KEEP_RST    = 1'b0;
	localparam logic [PATTERN_W-1:0] PATTERN_RST = 32'd10;
	localparam logic [DLEN_W-1:0]    DLEN_RST    = 3'd1;
	localparam logic [7:0]           DEFAULT_DELIM = 8'h0A;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_CONTENT_LENGTH = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_DELIMITER     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_PATTERN  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER_LENGTH   = 3'd3;

	localparam logic OP_PUSH    = 1'b0;
	localparam logic OP_DISCARD = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] stream_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       last_of_message;
		logic       empty_message;
	} out_t;

	typedef enum logic {
		FR_IDLE,
		FR_EMIT
	} fr_state_t;

endpackage
`default_nettype wire

[hw/rtl/delimiter_line_framer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delimiter_line_framer
// Collects bytes in a message store and emits each delimited message whose content fits the length limit.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while no delimiter completes; once a message
//   is framed, input is blocked while its beats are emitted (one beat for an
//   empty message) and during any output stall, set by the store's single read port.
// The first beat of a message passes the read stage and the output register after the closing byte.
// Reset: config registers return to defaults, pending count and history clear;
//   the store itself is not cleared and needs no clearing pass.
module delimiter_line_framer #(
	parameter int STORE_DEPTH         = dlf_pkg::STORE_DEPTH_DEF,
	parameter int MAX_DELIMITER_BYTES = dlf_pkg::MAX_DELIMITER_BYTES_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_ready,
	input  wire  dlf_pkg::in_t                    in_data,
	output logic                                  out_valid,
	input  wire                                   out_ready,
	output dlf_pkg::out_t                         out_data,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [dlf_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire  [dlf_pkg::PATTERN_W-1:0]         cfg_data
);

	localparam int AW  = $clog2(STORE_DEPTH);
	localparam int CW  = AW + 1;
	localparam int NB  = (MAX_DELIMITER_BYTES < 4) ? MAX_DELIMITER_BYTES : 4;
	localparam int RBW = 8 * NB;

	logic [dlf_pkg::LIMIT_W-1:0]   max_len_q;
	logic                          keep_q;
	logic [dlf_pkg::PATTERN_W-1:0] pattern_q;
	logic [dlf_pkg::DLEN_W-1:0]    dlen_cfg_q;

	logic [7:0]    store_mem [STORE_DEPTH];
	logic [7:0]    rdata_s1;
	logic          s1_valid;
	logic          s1_last;
	logic          s1_empty;

	dlf_pkg::fr_state_t state_q, state_d;
	logic [CW-1:0]  pending_q;
	logic [RBW-1:0] recent_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW-1:0]  emit_last_q;
	logic           empty_q;

	logic           out_valid_q;
	dlf_pkg::out_t  out_q;

	logic           accept;
	logic           push;
	logic           discard;
	logic           start_emit;
	logic           s1_move;
	logic           issue;
	logic           last_issue;

	logic [CW-1:0]  pending_new;
	logic [RBW-1:0] recent_new;
	logic [2:0]     dlen;
	logic [6:0]     limit_wide;
	logic [CW-1:0]  limit;
	logic [NB:1]    match_len;
	logic           match;
	logic [CW-1:0]  content;
	logic [CW-1:0]  emit_len;
	logic [7:0]     delim_byte [NB];

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign accept  = in_valid && in_ready;
	assign push    = accept && (in_data.operation == dlf_pkg::OP_PUSH);
	assign discard = accept && (in_data.operation == dlf_pkg::OP_DISCARD);

	assign s1_move = s1_valid && (!out_valid_q || out_ready);

	// Delimiter match on the history including the new byte
	always_comb begin
		pending_new = pending_q + CW'(1);
		recent_new  = (recent_q << 8) | RBW'(in_data.stream_byte);

		if (dlen_cfg_q == 3'd0) begin
			dlen = 3'd1;
		end else if (dlen_cfg_q > 3'(NB)) begin
			dlen = 3'(NB);
		end else begin
			dlen = dlen_cfg_q;
		end

		limit_wide = (7'(max_len_q) > 7'(STORE_DEPTH - 1)) ? 7'(STORE_DEPTH - 1)
		                                                   : 7'(max_len_q);
		limit = CW'(limit_wide);

		for (int i = 0; i < NB; i++) begin
			delim_byte[i] = (dlen_cfg_q == 3'd0) ? dlf_pkg::DEFAULT_DELIM
			                                     : pattern_q[8*i +: 8];
		end

		for (int l = 1; l <= NB; l++) begin
			match_len[l] = 1'b1;
			for (int i = 0; i < l; i++) begin
				if (recent_new[8*(l-1-i) +: 8] != delim_byte[i]) begin
					match_len[l] = 1'b0;
				end
			end
		end

		match = 1'b0;
		for (int l = 1; l <= NB; l++) begin
			if (dlen == 3'(l)) begin
				match = match_len[l];
			end
		end
		if (pending_new < CW'(dlen)) begin
			match = 1'b0;
		end

		content  = pending_new - CW'(dlen);
		emit_len = keep_q ? pending_new : content;
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		start_emit = 1'b0;
		issue      = 1'b0;
		last_issue = empty_q || (rd_ptr_q == emit_last_q);
		case (state_q)
			dlf_pkg::FR_IDLE: begin
				in_ready = 1'b1;
				if (push && match && (content <= limit)) begin
					start_emit = 1'b1;
					state_d    = dlf_pkg::FR_EMIT;
				end
			end
			dlf_pkg::FR_EMIT: begin
				issue = !s1_valid || s1_move;
				if (issue && last_issue) begin
					state_d = dlf_pkg::FR_IDLE;
				end
			end
			default: begin
				state_d = dlf_pkg::FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlf_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			store_mem[pending_q[AW-1:0]] <= in_data.stream_byte;
		end
		if (issue && !empty_q) begin
			rdata_s1 <= store_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= dlf_pkg::LIMIT_RST;
			keep_q     <= dlf_pkg::KEEP_RST;
			pattern_q  <= dlf_pkg::PATTERN_RST;
			dlen_cfg_q <= dlf_pkg::DLEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dlf_pkg::CFG_MAX_CONTENT_LENGTH: max_len_q  <= cfg_data[dlf_pkg::LIMIT_W-1:0];
				dlf_pkg::CFG_KEEP_DELIMITER:     keep_q     <= cfg_data[0];
				dlf_pkg::CFG_DELIMITER_PATTERN:  pattern_q  <= cfg_data;
				dlf_pkg::CFG_DELIMITER_LENGTH:   dlen_cfg_q <= cfg_data[dlf_pkg::DLEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			recent_q    <= '0;
			rd_ptr_q    <= '0;
			emit_last_q <= '0;
			empty_q     <= 1'b0;
		end else begin
			if (discard) begin
				pending_q <= '0;
				recent_q  <= '0;
			end else if (push) begin
				if (match || (pending_new > limit)) begin
					pending_q <= '0;
					recent_q  <= '0;
				end else begin
					pending_q <= pending_new;
					recent_q  <= recent_new;
				end
			end
			if (start_emit) begin
				rd_ptr_q    <= '0;
				emit_last_q <= AW'(emit_len - CW'(1));
				empty_q     <= (emit_len == '0);
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s1_last     <= 1'b0;
			s1_empty    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (issue) begin
				s1_valid <= 1'b1;
				s1_last  <= last_issue;
				s1_empty <= empty_q;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q           <= 1'b1;
				out_q.message_byte    <= s1_empty ? 8'd0 : rdata_s1;
				out_q.last_of_message <= s1_last;
				out_q.empty_message   <= s1_empty;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.empty_message |->
			out_q.last_of_message && (out_q.message_byte == 8'd0))
		else $error("empty beat not marked last or not zero");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CW'(STORE_DEPTH - 1))
		else $error("pending count beyond store");

	a_rd_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dlf_pkg::FR_EMIT) |-> (rd_ptr_q <= emit_last_q))
		else $error("read pointer past message end");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_move |=>
			s1_valid && $stable(s1_last) && (s1_empty || $stable(rdata_s1)))
		else $error("stalled read beat lost");

	a_no_input_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		start_emit |=> !in_ready)
		else $error("input taken while a message is emitted");

endmodule
`default_nettype wire
